FILE: sv/prdf_pkg.sv
// Package for the pressure reading direction filter.
// Status, direction, register index, operation and kind codes plus the classifier result type.
// No dependencies.
package prdf_pkg;

	localparam int unsigned AdcW     = 12;
	localparam int unsigned GainW    = 24;
	localparam int unsigned ReadW    = 8;
	localparam int unsigned TicksW   = 32;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 32;
	localparam int unsigned InDataW  = 48;
	localparam int unsigned OutDataW = 16;

	typedef enum logic [1:0] {
		ST_VALID = 2'd0,
		ST_FAULT = 2'd1,
		ST_UNDER = 2'd2,
		ST_OVER  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_GAIN       = 3'd0,
		REG_OFFSET     = 3'd1,
		REG_LOW_LIMIT  = 3'd2,
		REG_HIGH_LIMIT = 3'd3,
		REG_HOLD_TICKS = 3'd4
	} reg_idx_t;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic KIND_BROADCAST = 1'b0;
	localparam logic KIND_RESPONSE  = 1'b1;

	typedef struct packed {
		status_t           status;
		logic [ReadW-1:0]  reading;
	} class_t;

endpackage

FILE: sv/pressure_reading_direction_filter.sv
// Pressure reading direction filter: top level with input stage, state and result register.
// Depends on prdf_pkg and prdf_classify.
//
// Takes one item per cycle unless a waiting result stalls it on m_tready. An item sits in
// the input register, where the 12x24 scaling multiply, the limit compares and the hold-time
// compare decide it against the held state; the result, if any, lands in the output register.
// A sample that equals the held reading, or a reversal inside the hold time, produces no transfer;
// a read request always produces one (kind 1). Errors store at once with reading zero and clear
// the direction. Configuration must be written only while idle; the block does not enforce it.
module pressure_reading_direction_filter (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [prdf_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [prdf_pkg::CfgDataW-1:0]  cfg_data,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [prdf_pkg::InDataW-1:0]   s_tdata,   // adc_sample[11:0], adc_fault[12], now_ticks[44:13]
	input  logic                           s_tuser,   // operation
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [prdf_pkg::OutDataW-1:0]  m_tdata,   // status[1:0], reading[9:2]
	output logic                           m_tuser    // kind
);
	import prdf_pkg::*;

	// configuration registers
	logic [GainW-1:0]   gain_q;
	logic signed [31:0] offset_q;
	logic [ReadW-1:0]   low_q;
	logic [ReadW-1:0]   high_q;
	logic [TicksW-1:0]  hold_q;

	// held state
	logic [ReadW-1:0]   held_reading_q;
	status_t            held_status_q;
	dir_t               dir_q;
	logic [TicksW-1:0]  last_time_q;

	// input stage
	logic               valid_s1;
	logic               op_s1;
	logic [AdcW-1:0]    adc_s1;
	logic               fault_s1;
	logic [TicksW-1:0]  now_s1;

	// output register
	logic               out_valid_q;
	logic               out_kind_q;
	status_t            out_status_q;
	logic [ReadW-1:0]   out_reading_q;

	class_t             cls;
	logic [TicksW-1:0]  elapsed;
	logic               same;
	logic               take;
	logic               emit;
	logic               update;
	logic               adv_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GainW'(65536);
			offset_q <= '0;
			low_q    <= '0;
			high_q   <= '1;
			hold_q   <= TicksW'(1000);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN:       gain_q   <= cfg_data[GainW-1:0];
				REG_OFFSET:     offset_q <= $signed(cfg_data);
				REG_LOW_LIMIT:  low_q    <= cfg_data[ReadW-1:0];
				REG_HIGH_LIMIT: high_q   <= cfg_data[ReadW-1:0];
				REG_HOLD_TICKS: hold_q   <= cfg_data[TicksW-1:0];
				default: ;
			endcase
		end
	end

	prdf_classify u_classify (
		.adc_sample (adc_s1),
		.adc_fault  (fault_s1),
		.gain       (gain_q),
		.offset     (offset_q),
		.low_limit  (low_q),
		.high_limit (high_q),
		.result     (cls)
	);

	assign elapsed = now_s1 - last_time_q;
	assign same    = (cls.status == held_status_q) && (cls.reading == held_reading_q);

	always_comb begin
		take = 1'b0;
		if (held_status_q != ST_VALID || dir_q == DIR_NONE || elapsed >= hold_q) begin
			take = 1'b1;
		end else if (cls.reading > held_reading_q && dir_q == DIR_UP) begin
			take = 1'b1;
		end else if (cls.reading < held_reading_q && dir_q == DIR_DOWN) begin
			take = 1'b1;
		end
	end

	// state changes only for a sample that differs and is either an error or passes the filter
	assign update = (op_s1 == OP_SAMPLE) && !same && (cls.status != ST_VALID || take);
	assign emit   = (op_s1 == OP_READ) || update;
	assign adv_s1 = valid_s1 && (!emit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= s_tuser;
			adc_s1   <= s_tdata[AdcW-1:0];
			fault_s1 <= s_tdata[AdcW];
			now_s1   <= s_tdata[AdcW+TicksW:AdcW+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_reading_q <= '0;
			held_status_q  <= ST_VALID;
			dir_q          <= DIR_NONE;
			last_time_q    <= '0;
		end else if (adv_s1 && update) begin
			held_status_q  <= cls.status;
			held_reading_q <= cls.reading;
			if (cls.status != ST_VALID) begin
				dir_q <= DIR_NONE;
			end else begin
				// after an error the new value always counts as rising
				if (held_status_q != ST_VALID || cls.reading > held_reading_q) begin
					dir_q <= DIR_UP;
				end else begin
					dir_q <= DIR_DOWN;
				end
				last_time_q <= now_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			if (op_s1 == OP_READ) begin
				out_kind_q    <= KIND_RESPONSE;
				out_status_q  <= held_status_q;
				out_reading_q <= held_reading_q;
			end else begin
				out_kind_q    <= KIND_BROADCAST;
				out_status_q  <= cls.status;
				out_reading_q <= cls.reading;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {(OutDataW-ReadW-2)'(0), out_reading_q, out_status_q};

	// checks
	a_err_no_dir: assert property (@(posedge clk) disable iff (!arst_n)
		held_status_q != ST_VALID |-> dir_q == DIR_NONE)
		else $error("error status held with a direction");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		held_status_q != ST_VALID |-> held_reading_q == '0)
		else $error("error status held with nonzero reading");

	a_out_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_status_q != ST_VALID) |-> out_reading_q == '0)
		else $error("result with error status carries a reading");

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && emit) |=> m_tvalid)
		else $error("emitted result lost");

endmodule

FILE: sv/prdf_classify.sv
// Scales a raw ADC sample, (adc * gain + offset) >> 16 with floor, and classifies it.
// Depends on prdf_pkg.
module prdf_classify (
	input  logic [prdf_pkg::AdcW-1:0]  adc_sample,
	input  logic                       adc_fault,
	input  logic [prdf_pkg::GainW-1:0] gain,
	input  logic signed [31:0]         offset,
	input  logic [prdf_pkg::ReadW-1:0] low_limit,
	input  logic [prdf_pkg::ReadW-1:0] high_limit,
	output prdf_pkg::class_t           result
);
	import prdf_pkg::*;

	localparam int unsigned ProdW = AdcW + GainW;
	localparam int unsigned SumW  = ProdW + 2;

	logic [ProdW-1:0]       prod;
	logic signed [SumW-1:0] sum;
	logic [SumW-18:0]       scaled;   // non-negative part of sum >> 16
	logic                   neg;

	assign prod   = ProdW'(adc_sample) * ProdW'(gain);
	assign sum    = $signed({2'b00, prod}) + SumW'(offset);
	assign neg    = sum[SumW-1];
	assign scaled = sum[SumW-2:16];

	always_comb begin
		result.status  = ST_VALID;
		result.reading = '0;
		if (adc_fault) begin
			result.status = ST_FAULT;
		end else if (neg || scaled < (SumW-17)'(low_limit)) begin
			result.status = ST_UNDER;
		end else if (scaled > (SumW-17)'(high_limit)) begin
			result.status = ST_OVER;
		end else begin
			result.reading = scaled[ReadW-1:0];
		end
	end

endmodule
